### rtl/core/nic_descriptor_queue_registers_defines.svh
// ----------------------------------------------------------------------------
// NIC descriptor queue registers: assertion macros
// Shared macros for concurrent checks on the descriptor queue block.
// ----------------------------------------------------------------------------
`ifndef NIC_DESCRIPTOR_QUEUE_REGISTERS_DEFINES_SVH
`define NIC_DESCRIPTOR_QUEUE_REGISTERS_DEFINES_SVH

`define NICDQ_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

`define NICDQ_CHECK(lbl, prop, msg) \
  `NICDQ_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

### rtl/core/nicdq_pkg.sv
// ----------------------------------------------------------------------------
// NIC descriptor queue package
// Field widths, request kinds, register offsets, error codes and the
// command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package nicdq_pkg;

  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 4;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TX    = 2'd2;
  localparam logic [1:0] REQ_RX    = 2'd3;

  localparam logic [4:0] OFF_SEND_REQ  = 5'd0;
  localparam logic [4:0] OFF_RECV_REQ  = 5'd8;
  localparam logic [4:0] OFF_SEND_COMP = 5'd16;
  localparam logic [4:0] OFF_RECV_COMP = 5'd18;
  localparam logic [4:0] OFF_COUNTS    = 5'd20;
  localparam logic [4:0] OFF_MACADDR   = 5'd24;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_EMPTY  = 2'd2;
  localparam logic [1:0] ERR_OFFSET = 2'd3;

  typedef struct packed {
    logic latch;
    logic commit;
  } nicdq_cmd_t;

endpackage

### rtl/core/nic_descriptor_queue_registers.sv
// ----------------------------------------------------------------------------
// NIC descriptor queue registers: top level
// Takes one request at a time: the request latch stores it on acceptance, and the
// queue commit registers the result once the previous result has been taken or is being taken.
// Synchronous active-low reset empties all queues and clears the MAC address.
// ----------------------------------------------------------------------------
`include "nic_descriptor_queue_registers_defines.svh"

module nic_descriptor_queue_registers
  import nicdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [4:0]          in_reg_offset,
  input  logic [DATA_W-1:0]   in_write_data,
  input  logic [LEN_W-1:0]    in_frame_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [ADDR_W-1:0]   out_dma_address,
  output logic [LEN_W-1:0]    out_dma_length,
  output logic                out_dma_valid,
  output logic [1:0]          out_error_code,
  output logic                out_irq_pending
);

  nicdq_cmd_t cmd;

  assign cfg_ready = 1'b1;

  nicdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  nicdq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_req_type     (in_req_type),
    .in_reg_offset   (in_reg_offset),
    .in_write_data   (in_write_data),
    .in_frame_length (in_frame_length),
    .out_read_data   (out_read_data),
    .out_dma_address (out_dma_address),
    .out_dma_length  (out_dma_length),
    .out_dma_valid   (out_dma_valid),
    .out_error_code  (out_error_code),
    .out_irq_pending (out_irq_pending)
  );

  `NICDQ_CHECK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `NICDQ_CHECK(a_dma_no_error, (out_valid && out_dma_valid) |-> (out_error_code == ERR_OK), "dma with error")
  `NICDQ_CHECK(a_dma_no_rdata, (out_valid && out_dma_valid) |-> (out_read_data == '0), "dma with read data")

endmodule

### rtl/core/nicdq_ctrl.sv
// ----------------------------------------------------------------------------
// NIC descriptor queue controller
// Sequences one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module nicdq_ctrl
  import nicdq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output nicdq_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.latch  = in_valid && in_ready;
  assign cmd.commit = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.latch) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/nicdq_datapath.sv
// ----------------------------------------------------------------------------
// NIC descriptor queue datapath
// Request and completion queues, the station address register and the
// result register.
// ----------------------------------------------------------------------------
module nicdq_datapath
  import nicdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nicdq_cmd_t          cmd,
  input  logic                cfg_we,
  input  logic [ADDR_W-1:0]   cfg_data,
  input  logic [1:0]          in_req_type,
  input  logic [4:0]          in_reg_offset,
  input  logic [DATA_W-1:0]   in_write_data,
  input  logic [LEN_W-1:0]    in_frame_length,
  output logic [DATA_W-1:0]   out_read_data,
  output logic [ADDR_W-1:0]   out_dma_address,
  output logic [LEN_W-1:0]    out_dma_length,
  output logic                out_dma_valid,
  output logic [1:0]          out_error_code,
  output logic                out_irq_pending
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  logic [1:0]        req_type_r;
  logic [4:0]        reg_offset_r;
  logic [DATA_W-1:0] write_data_r;
  logic [LEN_W-1:0]  frame_length_r;
  logic [ADDR_W-1:0] mac_r;

  logic [DATA_W-1:0] sreq_mem [QUEUE_DEPTH];
  logic [ADDR_W-1:0] rreq_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0]  rdone_mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] sreq_rd_r;
  logic [ADDR_W-1:0] rreq_rd_r;
  logic [LEN_W-1:0]  rdone_rd_r;

  logic [PW-1:0] sreq_head_r, sreq_head_nxt;
  logic [FW-1:0] sreq_fill_r, sreq_fill_nxt;
  logic [PW-1:0] rreq_head_r, rreq_head_nxt;
  logic [FW-1:0] rreq_fill_r, rreq_fill_nxt;
  logic [FW-1:0] sdone_fill_r, sdone_fill_nxt;
  logic [PW-1:0] rdone_head_r, rdone_head_nxt;
  logic [FW-1:0] rdone_fill_r, rdone_fill_nxt;

  logic [PW-1:0] sreq_tail, rreq_tail, rdone_tail;
  logic          sreq_push, rreq_push, rdone_push;

  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] daddr;
  logic [LEN_W-1:0]  dlen;
  logic              dvalid;
  logic [1:0]        err;

  logic [DATA_W-1:0] read_data_r;
  logic [ADDR_W-1:0] dma_address_r;
  logic [LEN_W-1:0]  dma_length_r;
  logic              dma_valid_r;
  logic [1:0]        error_code_r;
  logic              irq_pending_r;

  function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] head,
                                             input logic [FW-1:0] fill);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(fill);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] head);
    return (head == LAST_SLOT) ? '0 : head + PW'(1);
  endfunction

  assign sreq_tail  = slot_add(sreq_head_r, sreq_fill_r);
  assign rreq_tail  = slot_add(rreq_head_r, rreq_fill_r);
  assign rdone_tail = slot_add(rdone_head_r, rdone_fill_r);

  always_comb begin
    rdata          = '0;
    daddr          = '0;
    dlen           = '0;
    dvalid         = 1'b0;
    err            = ERR_OK;
    sreq_push      = 1'b0;
    rreq_push      = 1'b0;
    rdone_push     = 1'b0;
    sreq_head_nxt  = sreq_head_r;
    sreq_fill_nxt  = sreq_fill_r;
    rreq_head_nxt  = rreq_head_r;
    rreq_fill_nxt  = rreq_fill_r;
    sdone_fill_nxt = sdone_fill_r;
    rdone_head_nxt = rdone_head_r;
    rdone_fill_nxt = rdone_fill_r;
    unique case (req_type_r)
      REQ_WRITE: begin
        unique case (reg_offset_r)
          OFF_SEND_REQ: begin
            if (sreq_fill_r == FULL_FILL) begin
              err = ERR_FULL;
            end else begin
              sreq_push     = 1'b1;
              sreq_fill_nxt = sreq_fill_r + FW'(1);
            end
          end
          OFF_RECV_REQ: begin
            if (rreq_fill_r == FULL_FILL) begin
              err = ERR_FULL;
            end else begin
              rreq_push     = 1'b1;
              rreq_fill_nxt = rreq_fill_r + FW'(1);
            end
          end
          default: err = ERR_OFFSET;
        endcase
      end
      REQ_READ: begin
        unique case (reg_offset_r)
          OFF_SEND_COMP: begin
            if (sdone_fill_r == '0) begin
              err = ERR_EMPTY;
            end else begin
              sdone_fill_nxt = sdone_fill_r - FW'(1);
            end
          end
          OFF_RECV_COMP: begin
            if (rdone_fill_r == '0) begin
              err = ERR_EMPTY;
            end else begin
              rdata          = DATA_W'(rdone_rd_r);
              rdone_head_nxt = slot_next(rdone_head_r);
              rdone_fill_nxt = rdone_fill_r - FW'(1);
            end
          end
          OFF_COUNTS: begin
            rdata = DATA_W'({COUNT_W'(rdone_fill_r), COUNT_W'(sdone_fill_r),
                             COUNT_W'(FULL_FILL - rreq_fill_r),
                             COUNT_W'(FULL_FILL - sreq_fill_r)});
          end
          OFF_MACADDR: rdata = DATA_W'(mac_r);
          default:     err = ERR_OFFSET;
        endcase
      end
      REQ_TX: begin
        if (sreq_fill_r == '0) begin
          err = ERR_EMPTY;
        end else if (sdone_fill_r == FULL_FILL) begin
          err = ERR_FULL;
        end else begin
          daddr          = sreq_rd_r[ADDR_W-1:0];
          dlen           = sreq_rd_r[DATA_W-1:ADDR_W];
          dvalid         = 1'b1;
          sreq_head_nxt  = slot_next(sreq_head_r);
          sreq_fill_nxt  = sreq_fill_r - FW'(1);
          sdone_fill_nxt = sdone_fill_r + FW'(1);
        end
      end
      REQ_RX: begin
        if (rreq_fill_r == '0) begin
          err = ERR_EMPTY;
        end else if (rdone_fill_r == FULL_FILL) begin
          err = ERR_FULL;
        end else begin
          daddr          = rreq_rd_r;
          dlen           = frame_length_r;
          dvalid         = 1'b1;
          rdone_push     = 1'b1;
          rreq_head_nxt  = slot_next(rreq_head_r);
          rreq_fill_nxt  = rreq_fill_r - FW'(1);
          rdone_fill_nxt = rdone_fill_r + FW'(1);
        end
      end
      default: err = ERR_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    sreq_rd_r  <= sreq_mem[sreq_head_r];
    rreq_rd_r  <= rreq_mem[rreq_head_r];
    rdone_rd_r <= rdone_mem[rdone_head_r];
    if (cmd.commit && sreq_push) begin
      sreq_mem[sreq_tail] <= write_data_r;
    end
    if (cmd.commit && rreq_push) begin
      rreq_mem[rreq_tail] <= write_data_r[ADDR_W-1:0];
    end
    if (cmd.commit && rdone_push) begin
      rdone_mem[rdone_tail] <= frame_length_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_r     <= in_req_type;
      reg_offset_r   <= in_reg_offset;
      write_data_r   <= in_write_data;
      frame_length_r <= in_frame_length;
    end
    if (cmd.commit) begin
      read_data_r   <= rdata;
      dma_address_r <= daddr;
      dma_length_r  <= dlen;
      dma_valid_r   <= dvalid;
      error_code_r  <= err;
      irq_pending_r <= (sdone_fill_nxt != '0) || (rdone_fill_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r        <= '0;
      sreq_head_r  <= '0;
      sreq_fill_r  <= '0;
      rreq_head_r  <= '0;
      rreq_fill_r  <= '0;
      sdone_fill_r <= '0;
      rdone_head_r <= '0;
      rdone_fill_r <= '0;
    end else begin
      if (cfg_we) begin
        mac_r <= cfg_data;
      end
      if (cmd.commit) begin
        sreq_head_r  <= sreq_head_nxt;
        sreq_fill_r  <= sreq_fill_nxt;
        rreq_head_r  <= rreq_head_nxt;
        rreq_fill_r  <= rreq_fill_nxt;
        sdone_fill_r <= sdone_fill_nxt;
        rdone_head_r <= rdone_head_nxt;
        rdone_fill_r <= rdone_fill_nxt;
      end
    end
  end

  assign out_read_data   = read_data_r;
  assign out_dma_address = dma_address_r;
  assign out_dma_length  = dma_length_r;
  assign out_dma_valid   = dma_valid_r;
  assign out_error_code  = error_code_r;
  assign out_irq_pending = irq_pending_r;

endmodule

### dv/nic_descriptor_queue_registers_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NIC descriptor queue registers: transfer checker
// Watches the configuration, request and result channels, keeps its own copy
// of the four queues and the MAC address, predicts the result of every
// accepted request and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module nic_descriptor_queue_registers_checker
  import nicdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [4:0]        in_reg_offset,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [LEN_W-1:0]  in_frame_length,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_read_data,
  input  logic [ADDR_W-1:0] out_dma_address,
  input  logic [LEN_W-1:0]  out_dma_length,
  input  logic              out_dma_valid,
  input  logic [1:0]        out_error_code,
  input  logic              out_irq_pending,
  output int                pending,
  output int                mismatches
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [ADDR_W-1:0] dma_address;
    logic [LEN_W-1:0]  dma_length;
    logic              dma_valid;
    logic [1:0]        error_code;
    logic              irq_pending;
  } nic_result_t;

  logic [ADDR_W-1:0]  mac_shadow;
  logic [DATA_W-1:0]  send_desc_mem [QUEUE_DEPTH];
  logic [ADDR_W-1:0]  recv_buf_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0]   recv_len_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   send_desc_head;
  logic [PTR_W-1:0]   recv_buf_head;
  logic [PTR_W-1:0]   recv_len_head;
  logic [COUNT_W-1:0] send_desc_fill;
  logic [COUNT_W-1:0] recv_buf_fill;
  logic [COUNT_W-1:0] send_done_fill;
  logic [COUNT_W-1:0] recv_len_fill;
  nic_result_t        expected_results [$];
  int                 error_total;

  function automatic logic [PTR_W-1:0] wrap_slot(input int unsigned slot);
    return PTR_W'(slot % QUEUE_DEPTH);
  endfunction

  function automatic nic_result_t queue_request(input logic [1:0]        kind,
                                                input logic [4:0]        off,
                                                input logic [DATA_W-1:0] wdata,
                                                input logic [LEN_W-1:0]  flen);
    nic_result_t       r;
    logic [DATA_W-1:0] desc;
    r = '0;
    case (kind)
      REQ_WRITE: begin
        if (off == OFF_SEND_REQ) begin
          if (send_desc_fill >= QUEUE_DEPTH) begin
            r.error_code = ERR_FULL;
          end else begin
            send_desc_mem[wrap_slot(send_desc_head + send_desc_fill)] = wdata;
            send_desc_fill++;
          end
        end else if (off == OFF_RECV_REQ) begin
          if (recv_buf_fill >= QUEUE_DEPTH) begin
            r.error_code = ERR_FULL;
          end else begin
            recv_buf_mem[wrap_slot(recv_buf_head + recv_buf_fill)] = wdata[ADDR_W-1:0];
            recv_buf_fill++;
          end
        end else begin
          r.error_code = ERR_OFFSET;
        end
      end
      REQ_READ: begin
        if (off == OFF_SEND_COMP) begin
          if (send_done_fill == 0) r.error_code = ERR_EMPTY;
          else send_done_fill--;
        end else if (off == OFF_RECV_COMP) begin
          if (recv_len_fill == 0) begin
            r.error_code = ERR_EMPTY;
          end else begin
            r.read_data = {{(DATA_W-LEN_W){1'b0}}, recv_len_mem[recv_len_head]};
            recv_len_head = wrap_slot(recv_len_head + 1);
            recv_len_fill--;
          end
        end else if (off == OFF_COUNTS) begin
          r.read_data = {{(DATA_W-4*COUNT_W){1'b0}}, recv_len_fill, send_done_fill,
                         COUNT_W'(QUEUE_DEPTH - recv_buf_fill),
                         COUNT_W'(QUEUE_DEPTH - send_desc_fill)};
        end else if (off == OFF_MACADDR) begin
          r.read_data = {{(DATA_W-ADDR_W){1'b0}}, mac_shadow};
        end else begin
          r.error_code = ERR_OFFSET;
        end
      end
      REQ_TX: begin
        if (send_desc_fill == 0) begin
          r.error_code = ERR_EMPTY;
        end else if (send_done_fill >= QUEUE_DEPTH) begin
          r.error_code = ERR_FULL;
        end else begin
          desc = send_desc_mem[send_desc_head];
          send_desc_head = wrap_slot(send_desc_head + 1);
          send_desc_fill--;
          send_done_fill++;
          r.dma_address = desc[ADDR_W-1:0];
          r.dma_length = desc[DATA_W-1:ADDR_W];
          r.dma_valid = 1'b1;
        end
      end
      default: begin
        if (recv_buf_fill == 0) begin
          r.error_code = ERR_EMPTY;
        end else if (recv_len_fill >= QUEUE_DEPTH) begin
          r.error_code = ERR_FULL;
        end else begin
          r.dma_address = recv_buf_mem[recv_buf_head];
          recv_buf_head = wrap_slot(recv_buf_head + 1);
          recv_buf_fill--;
          recv_len_mem[wrap_slot(recv_len_head + recv_len_fill)] = flen;
          recv_len_fill++;
          r.dma_length = flen;
          r.dma_valid = 1'b1;
        end
      end
    endcase
    r.irq_pending = (send_done_fill != 0) || (recv_len_fill != 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_total++;
    end
  endtask

  always @(posedge clk) begin : monitor
    nic_result_t seen;
    nic_result_t want;
    if (!rst_n) begin
      mac_shadow = '0;
      send_desc_head = '0;
      recv_buf_head = '0;
      recv_len_head = '0;
      send_desc_fill = '0;
      recv_buf_fill = '0;
      send_done_fill = '0;
      recv_len_fill = '0;
      expected_results.delete();
      error_total = 0;
    end else begin
      if (cfg_valid && cfg_ready) mac_shadow = cfg_data;
      if (in_valid && in_ready) begin
        expected_results.push_back(queue_request(in_req_type, in_reg_offset,
                                                 in_write_data, in_frame_length));
      end
      if (out_valid && out_ready) begin
        seen = '{out_read_data, out_dma_address, out_dma_length, out_dma_valid,
                 out_error_code, out_irq_pending};
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transfer expected none, got 0x%0h", $time, seen);
          error_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, seen.read_data);
          check_field("dma_address", want.dma_address, seen.dma_address);
          check_field("dma_length", want.dma_length, seen.dma_length);
          check_field("dma_valid", want.dma_valid, seen.dma_valid);
          check_field("error_code", want.error_code, seen.error_code);
          check_field("irq_pending", want.irq_pending, seen.irq_pending);
        end
      end
    end
    pending <= expected_results.size();
    mismatches <= error_total;
  end

endmodule

### dv/nic_descriptor_queue_registers_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NIC descriptor queue registers: testbench top
// Drives register accesses and datapath events in bursts, stalls the result
// side on its own pattern, reprograms the MAC address between idle phases
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module nic_descriptor_queue_registers_test
  import nicdq_pkg::*;
();

  localparam int QUEUE_DEPTH = 8;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 310;
  localparam logic [4:0] OFF_UNMAPPED = 5'd31;

  typedef enum int {MIX_FILL, MIX_PILE_UP, MIX_DRAIN, MIX_NOISE} traffic_mix_t;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_FOURTH, READY_SPARSE} ready_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [4:0]        in_reg_offset;
  logic [DATA_W-1:0] in_write_data;
  logic [LEN_W-1:0]  in_frame_length;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_read_data;
  logic [ADDR_W-1:0] out_dma_address;
  logic [LEN_W-1:0]  out_dma_length;
  logic              out_dma_valid;
  logic [1:0]        out_error_code;
  logic              out_irq_pending;
  int                pending;
  int                mismatches;
  int unsigned       burst_left = 1;
  ready_mode_t       ready_mode = READY_ALWAYS;
  int unsigned       ready_span = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nic_descriptor_queue_registers #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_reg_offset   (in_reg_offset),
    .in_write_data   (in_write_data),
    .in_frame_length (in_frame_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_dma_address (out_dma_address),
    .out_dma_length  (out_dma_length),
    .out_dma_valid   (out_dma_valid),
    .out_error_code  (out_error_code),
    .out_irq_pending (out_irq_pending)
  );

  nic_descriptor_queue_registers_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_reg_offset   (in_reg_offset),
    .in_write_data   (in_write_data),
    .in_frame_length (in_frame_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_dma_address (out_dma_address),
    .out_dma_length  (out_dma_length),
    .out_dma_valid   (out_dma_valid),
    .out_error_code  (out_error_code),
    .out_irq_pending (out_irq_pending),
    .pending         (pending),
    .mismatches      (mismatches)
  );

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode = ready_mode_t'($urandom_range(3));
      ready_span = $urandom_range(10, 80);
    end else begin
      ready_span--;
    end
    case (ready_mode)
      READY_ALWAYS:       out_ready <= 1'b1;
      READY_COIN:         out_ready <= ($urandom_range(1) == 1);
      READY_EVERY_FOURTH: out_ready <= (ready_span % 4 == 0);
      default:            out_ready <= ($urandom_range(3) == 0);
    endcase
  end

  task automatic write_mac(input logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [4:0] off,
                          input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] flen);
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_reg_offset <= off;
    in_write_data <= data;
    in_frame_length <= flen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
  endtask

  // The sender holds off here until every predicted result has come back.
  task automatic wait_idle();
    if (burst_left != 0) in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] any_event();
    return ($urandom_range(1) == 1) ? REQ_TX : REQ_RX;
  endfunction

  task automatic send_random(input traffic_mix_t mix);
    logic [1:0]        kind;
    logic [4:0]        off;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  flen;
    int unsigned       roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:    kind = (roll < 80) ? REQ_WRITE : (roll < 90) ? REQ_READ : any_event();
      MIX_PILE_UP: kind = (roll < 45) ? REQ_WRITE : any_event();
      MIX_DRAIN:   kind = (roll < 70) ? REQ_READ : any_event();
      default:     kind = 2'($urandom_range(3));
    endcase
    case (kind)
      REQ_WRITE: off = ($urandom_range(1) == 1) ? OFF_RECV_REQ : OFF_SEND_REQ;
      REQ_READ: begin
        case ($urandom_range(5))
          0:       off = OFF_COUNTS;
          1:       off = OFF_MACADDR;
          2, 3:    off = OFF_SEND_COMP;
          default: off = OFF_RECV_COMP;
        endcase
      end
      default: off = 5'($urandom);
    endcase
    if ((mix == MIX_NOISE) ? ($urandom_range(1) == 1) : ($urandom_range(24) == 0)) begin
      off = 5'($urandom);
    end
    case ($urandom_range(9))
      0:       data = '0;
      1:       data = '1;
      default: data = {$urandom, $urandom};
    endcase
    case ($urandom_range(9))
      0:       flen = '0;
      1:       flen = '1;
      default: flen = LEN_W'($urandom);
    endcase
    send_req(kind, off, data, flen);
  endtask

  initial begin
    #5_000_000;
    $display("%0t ns: run did not finish in time", $time);
    $display("nic_descriptor_queue_registers: mismatch");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] mac_plan [PHASES];
    traffic_mix_t      mix;
    int unsigned       mix_left;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = REQ_WRITE;
    in_reg_offset = OFF_SEND_REQ;
    in_write_data = '0;
    in_frame_length = '0;
    out_ready = 1'b0;
    mix = MIX_FILL;
    mix_left = 0;
    mac_plan = '{'0, 48'h5555_5555_5555, 48'haaaa_aaaa_aaaa, '1, '0, '1};
    mac_plan[4] = ADDR_W'({$urandom, $urandom});
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_mac('1);

    send_req(REQ_READ, OFF_COUNTS, '0, '0);
    send_req(REQ_READ, OFF_MACADDR, '0, '0);
    send_req(REQ_READ, OFF_SEND_COMP, '0, '0);
    send_req(REQ_READ, OFF_RECV_COMP, '0, '0);
    send_req(REQ_TX, OFF_UNMAPPED, '1, '1);
    send_req(REQ_RX, OFF_UNMAPPED, '1, '1);
    send_req(REQ_WRITE, OFF_UNMAPPED, '1, '1);
    send_req(REQ_READ, OFF_SEND_REQ, '1, '1);
    send_req(REQ_WRITE, OFF_SEND_REQ, '1, '0);
    send_req(REQ_WRITE, OFF_SEND_REQ, '0, '0);
    send_req(REQ_WRITE, OFF_RECV_REQ, '1, '0);
    send_req(REQ_WRITE, OFF_RECV_REQ, '0, '0);
    send_req(REQ_READ, OFF_COUNTS, '0, '0);
    send_req(REQ_TX, OFF_SEND_REQ, '0, '0);
    send_req(REQ_RX, OFF_RECV_REQ, '0, '1);
    send_req(REQ_READ, OFF_COUNTS, '0, '0);
    send_req(REQ_READ, OFF_SEND_COMP, '0, '0);
    send_req(REQ_READ, OFF_RECV_COMP, '0, '0);
    send_req(REQ_TX, OFF_SEND_REQ, '0, '0);
    send_req(REQ_RX, OFF_RECV_REQ, '0, '0);
    send_req(REQ_READ, OFF_RECV_COMP, '0, '0);
    send_req(REQ_READ, OFF_SEND_COMP, '0, '0);
    send_req(REQ_READ, OFF_COUNTS, '0, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_mac(mac_plan[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (mix_left == 0) begin
          mix = traffic_mix_t'($urandom_range(3));
          mix_left = $urandom_range(15, 50);
        end
        mix_left--;
        send_random(mix);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("nic_descriptor_queue_registers: match");
    end else begin
      $display("nic_descriptor_queue_registers: mismatch");
    end
    $finish;
  end

endmodule
